/* hdl/mse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mse_pkg
// Shared types and constants for the merge sort engine: controller states,
// datapath command and status bundles, default store depth.
// ============================================================================
package mse_pkg;

    // default number of entries in the data and scratch stores
    localparam int unsigned MAX_COUNT_DEF = 64;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MERGE,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // store one incoming element
        logic sort_init;   // final element seen, prepare first pass
        logic pass_init;   // start a merge pass at the next run width
        logic merge_step;  // move one element into the destination buffer
        logic emit_init;   // point the read head at the sorted buffer start
        logic emit_step;   // present one sorted element
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sort_done;   // next run width covers the whole set
        logic pass_end;    // current merge step writes the last element
        logic emit_last;   // current emit step is the final element
    } t_dp_status;

endpackage
`default_nettype wire

/* hdl/merge_sort_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// merge_sort_engine
// Collects signed 32-bit elements and returns them in ascending order.
// ============================================================================
// Elements are loaded one per cycle while busy is low; an element beyond
// MAX_COUNT is dropped and flags every result of that run as overflowed.
// The element marked last starts a bottom-up merge sort that ping-pongs
// between the data and scratch stores, one element per cycle, with a
// setup state ahead of each pass: for n elements the sort runs ceil(log2 n)
// merge passes, then the results leave one per cycle after a final
// setup state. The merge rate is set by the single compare-and-write
// step per cycle.
// Results are held for exactly one cycle under o_strobe and cannot be
// stalled; busy stays high from the last element until the cycle that
// carries the final result, in which the next set may already load.
// ============================================================================
module merge_sort_engine #(
    parameter int unsigned MAX_COUNT = mse_pkg::MAX_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_value,
    input  wire logic        i_last_item,
    output logic             o_strobe,
    output logic [31:0]      o_sorted_value,
    output logic             o_last_result,
    output logic             o_overflowed
);

    mse_pkg::t_dp_cmd    dp_cmd;
    mse_pkg::t_dp_status dp_status;

    // sequencer
    mse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_item (i_last_item),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_busy      (busy)
    );

    // stores and merge logic
    mse_datapath #(
        .MAX_COUNT (MAX_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_value        (i_value),
        .o_status       (dp_status),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_overflowed   (o_overflowed)
    );

endmodule
`default_nettype wire

/* hdl/mse_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mse_ctrl
// Sequencer for the merge sort engine: load, merge passes, result run.
// ============================================================================
module mse_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_last_item,
    input  wire mse_pkg::t_dp_status i_status,
    output mse_pkg::t_dp_cmd        o_cmd,
    output logic                    o_busy
);

    mse_pkg::t_state r_state;
    mse_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != mse_pkg::ST_IDLE);
        unique case (r_state)
            mse_pkg::ST_IDLE: begin
                o_cmd.load      = i_start;
                o_cmd.sort_init = i_start && i_last_item;
                if (i_start && i_last_item) begin
                    n_state = mse_pkg::ST_SETUP;
                end
            end
            mse_pkg::ST_SETUP: begin
                if (i_status.sort_done) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = mse_pkg::ST_EMIT;
                end else begin
                    o_cmd.pass_init = 1'b1;
                    n_state         = mse_pkg::ST_MERGE;
                end
            end
            mse_pkg::ST_MERGE: begin
                o_cmd.merge_step = 1'b1;
                if (i_status.pass_end) begin
                    n_state = mse_pkg::ST_SETUP;
                end
            end
            mse_pkg::ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_status.emit_last) begin
                    n_state = mse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/mse_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mse_datapath
// Two ping-pong stores with two registered read ports each, merge heads,
// run bounds, element count and the registered result outputs.
// ============================================================================
module mse_datapath #(
    parameter int unsigned MAX_COUNT = mse_pkg::MAX_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mse_pkg::t_dp_cmd   i_cmd,
    input  wire logic [31:0]        i_value,
    output mse_pkg::t_dp_status     o_status,
    output logic                    o_strobe,
    output logic [31:0]             o_sorted_value,
    output logic                    o_last_result,
    output logic                    o_overflowed
);

    localparam int unsigned AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam int unsigned CW = $clog2(MAX_COUNT + 1);
    localparam int unsigned SW = CW + 1;

    // stores: mem0 holds loaded data, mem1 is scratch
    logic [31:0] mem0 [MAX_COUNT];
    logic [31:0] mem1 [MAX_COUNT];

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf,   n_ovf;
    logic [CW-1:0] r_width, n_width;
    logic          r_src,   n_src;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;

    logic [31:0] r_rd0_a, r_rd0_b, r_rd1_a, r_rd1_b;
    logic        r_strobe;
    logic [31:0] r_out_value;
    logic        r_out_last;
    logic        r_out_ovf;

    logic signed [31:0] head_a, head_b;
    logic               take_a;
    logic [SW-1:0]      setup_w;
    logic [CW-1:0]      bnd_lo;
    logic [SW-1:0]      bnd_w;
    logic [SW-1:0]      sum_mid, sum_hi;
    logic [CW-1:0]      bnd_mid, bnd_hi;
    logic [CW-1:0]      k_inc;
    logic [CW-1:0]      i_inc;
    logic               store_ok;
    logic               we0, we1;
    logic [AW-1:0]      wa0, wa1;
    logic [31:0]        wd;

    // merge heads come from the current source buffer
    assign head_a = r_src ? r_rd1_a : r_rd0_a;
    assign head_b = r_src ? r_rd1_b : r_rd0_b;
    assign take_a = (r_i < r_mid) && ((r_j >= r_hi) || (head_a < head_b));

    // run width for the next pass: 1 first, then doubled
    assign setup_w = (r_width == '0) ? SW'(1) : {r_width, 1'b0};

    // bounds of the next run pair, clipped to the element count
    assign bnd_lo  = i_cmd.pass_init ? '0 : r_hi;
    assign bnd_w   = i_cmd.pass_init ? setup_w : {1'b0, r_width};
    assign sum_mid = {1'b0, bnd_lo} + bnd_w;
    assign bnd_mid = (sum_mid > {1'b0, r_count}) ? r_count : sum_mid[CW-1:0];
    assign sum_hi  = {1'b0, bnd_mid} + bnd_w;
    assign bnd_hi  = (sum_hi > {1'b0, r_count}) ? r_count : sum_hi[CW-1:0];

    assign k_inc    = r_k + CW'(1);
    assign i_inc    = r_i + CW'(1);
    assign store_ok = (r_count < CW'(MAX_COUNT));

    // status to controller
    always_comb begin
        o_status.sort_done = (setup_w >= {1'b0, r_count});
        o_status.pass_end  = (k_inc == r_count);
        o_status.emit_last = (i_inc == r_count);
    end

    // store write ports
    always_comb begin
        we0 = (i_cmd.load && store_ok) || (i_cmd.merge_step && r_src);
        wa0 = i_cmd.load ? r_count[AW-1:0] : r_k[AW-1:0];
        we1 = i_cmd.merge_step && !r_src;
        wa1 = r_k[AW-1:0];
        wd  = i_cmd.load ? i_value : (take_a ? head_a : head_b);
    end

    // index and control next values
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_width = r_width;
        n_src   = r_src;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_mid   = r_mid;
        n_hi    = r_hi;

        if (i_cmd.load) begin
            if (store_ok) begin
                n_count = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_cmd.sort_init) begin
            n_width = '0;
            n_src   = 1'b0;
        end

        if (i_cmd.pass_init) begin
            n_width = setup_w[CW-1:0];
            n_src   = (r_width != '0) ? ~r_src : r_src;
            n_i     = '0;
            n_k     = '0;
            n_mid   = bnd_mid;
            n_j     = bnd_mid;
            n_hi    = bnd_hi;
        end

        if (i_cmd.merge_step) begin
            n_k = k_inc;
            if (take_a) begin
                n_i = i_inc;
            end else begin
                n_j = r_j + CW'(1);
            end
            // run pair finished: move to the next pair
            if (k_inc == r_hi) begin
                n_i   = r_hi;
                n_mid = bnd_mid;
                n_j   = bnd_mid;
                n_hi  = bnd_hi;
            end
        end

        if (i_cmd.emit_init) begin
            n_src = (r_width != '0) ? ~r_src : r_src;
            n_i   = '0;
        end

        if (i_cmd.emit_step) begin
            n_i = i_inc;
            if (o_status.emit_last) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_strobe <= i_cmd.emit_step;
        end
    end

    // indices and result payload
    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_src   <= n_src;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        if (i_cmd.emit_step) begin
            r_out_value <= head_a;
            r_out_last  <= o_status.emit_last;
            r_out_ovf   <= r_ovf;
        end
    end

    // data store, read ahead at the next head indices
    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[wa0] <= wd;
        end
        r_rd0_a <= mem0[n_i[AW-1:0]];
        r_rd0_b <= mem0[n_j[AW-1:0]];
    end

    // scratch store
    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[wa1] <= wd;
        end
        r_rd1_a <= mem1[n_i[AW-1:0]];
        r_rd1_b <= mem1[n_j[AW-1:0]];
    end

    assign o_strobe       = r_strobe;
    assign o_sorted_value = r_out_value;
    assign o_last_result  = r_out_last;
    assign o_overflowed   = r_out_ovf;

endmodule
`default_nettype wire

/* hdl/mse_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mse_checker
// Port-level checks on the merge sort engine's transaction sequencing.
// ============================================================================
module mse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [31:0] i_value,
    input wire logic        i_last_item,
    input wire logic        o_strobe,
    input wire logic [31:0] o_sorted_value,
    input wire logic        o_last_result,
    input wire logic        o_overflowed
);

    // a final element always starts the sort
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_item) |=> busy)
        else $error("final element did not start the sort");

    // a plain element leaves the engine ready for the next one
    a_load_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_item) |=> !busy)
        else $error("engine went busy on a non-final element");

    // results of a run come back to back until the final one
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_result) |=> (o_strobe && $stable(o_overflowed)))
        else $error("result run broken or overflow flag changed mid-run");

    // no result directly follows the final result, and results only come out of a sort
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_result) |=> !o_strobe)
        else $error("result issued after the final result");

    a_result_from_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(busy))
        else $error("result run started while the engine was idle");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);
`default_nettype wire
